>>> rtl/rva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rva_pkg
// Shared types, widths and pipeline depths of the axis-angle rotation core.
// ----------------------------------------------------------------------------
package rva_pkg;

  // Component and angle formats
  localparam int CW  = 32;   // Q16.16 vector components
  localparam int AW  = 32;   // Q4.28 angle
  localparam int NW  = 32;   // Q2.30 unit axis
  localparam int CSW = 34;   // Q2.30 cos/sin with headroom

  // CORDIC: reduction stage, step stages, sign-flip stage
  localparam int CORD_STEPS  = 30;
  localparam int CORD_PER    = 2;
  localparam int CORD_STAGES = CORD_STEPS / CORD_PER;
  localparam int CORD_LAT    = CORD_STAGES + 2;

  // Axis normalization: isqrt and reciprocal, two steps per stage
  localparam int SQ_STEPS   = 32;
  localparam int SQ_PER     = 2;
  localparam int SQ_STAGES  = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = DIV_STEPS / DIV_PER;
  localparam int MD_DEPTH   = SQ_STAGES + DIV_STAGES + 3;
  localparam int NORM_LAT   = SQ_STAGES + DIV_STAGES + 6;

  // Rotation tail after the unit axis is ready
  localparam int CS_DLY      = NORM_LAT - CORD_LAT;
  localparam int TAIL_STAGES = 6;
  localparam int PIPE_LAT    = NORM_LAT + TAIL_STAGES;

  typedef logic signed [CW-1:0]  comp_t;
  typedef logic signed [AW-1:0]  angle_t;
  typedef logic signed [NW-1:0]  unit_t;
  typedef logic signed [CSW-1:0] trig_t;

  typedef struct packed {
    comp_t  vec_x;
    comp_t  vec_y;
    comp_t  vec_z;
    angle_t angle;
    comp_t  axis_x;
    comp_t  axis_y;
    comp_t  axis_z;
  } in_t;

  typedef struct packed {
    comp_t rot_x;
    comp_t rot_y;
    comp_t rot_z;
    logic  axis_zero;
    logic  saturated;
  } out_t;

endpackage
`default_nettype wire

>>> rtl/rva_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rva_cordic
// Pipelined rotation-mode CORDIC giving cos and sin of a Q4.28 angle.
// ----------------------------------------------------------------------------
module rva_cordic (
  input  logic           clk_i,
  input  logic           en_i,
  input  rva_pkg::angle_t angle_i,
  output rva_pkg::trig_t cos_o,
  output rva_pkg::trig_t sin_o
);

  typedef struct packed {
    rva_pkg::trig_t x;
    rva_pkg::trig_t y;
    rva_pkg::trig_t z;
    logic           flip;
  } cord_t;

  localparam rva_pkg::trig_t AngPi     = 34'sd843314857;
  localparam rva_pkg::trig_t AngTwoPi  = 34'sd1686629713;
  localparam rva_pkg::trig_t AngHalfPi = 34'sd421657428;
  localparam rva_pkg::trig_t Gain      = 34'sd652032874;

  // floor(atan(2^-i) * 2^30)
  function automatic rva_pkg::trig_t atan_f(input int unsigned i);
    rva_pkg::trig_t v;
    case (i)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd7;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic cord_t cord_stage(input cord_t s, input int unsigned k);
    cord_t          r;
    rva_pkg::trig_t dx;
    rva_pkg::trig_t dy;
    int unsigned    i;
    r = s;
    for (int j = 0; j < rva_pkg::CORD_PER; j++) begin
      i  = k * rva_pkg::CORD_PER + j;
      dx = r.y >>> i;
      dy = r.x >>> i;
      if (!r.z[rva_pkg::CSW-1]) begin
        r.x = r.x - dx;
        r.y = r.y + dy;
        r.z = r.z - atan_f(i);
      end else begin
        r.x = r.x + dx;
        r.y = r.y - dy;
        r.z = r.z + atan_f(i);
      end
    end
    return r;
  endfunction

  rva_pkg::trig_t th;
  logic           flip;
  cord_t          red_d;
  cord_t          st_q [rva_pkg::CORD_STAGES+1];
  rva_pkg::trig_t cos_q;
  rva_pkg::trig_t sin_q;

  // wrap into -pi..pi, then fold into -pi/2..pi/2 with a half-turn flip
  always_comb begin
    th   = rva_pkg::CSW'(angle_i);
    flip = 1'b0;
    if (th > AngPi) begin
      th = th - AngTwoPi;
    end else if (th < -AngPi) begin
      th = th + AngTwoPi;
    end
    if (th > AngHalfPi) begin
      th   = th - AngPi;
      flip = 1'b1;
    end else if (th < -AngHalfPi) begin
      th   = th + AngPi;
      flip = 1'b1;
    end
    red_d.x    = Gain;
    red_d.y    = '0;
    red_d.z    = th <<< 2;
    red_d.flip = flip;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= red_d;
      for (int k = 0; k < rva_pkg::CORD_STAGES; k++) begin
        st_q[k+1] <= cord_stage(st_q[k], k);
      end
      cos_q <= st_q[rva_pkg::CORD_STAGES].flip ? -st_q[rva_pkg::CORD_STAGES].x
                                               : st_q[rva_pkg::CORD_STAGES].x;
      sin_q <= st_q[rva_pkg::CORD_STAGES].flip ? -st_q[rva_pkg::CORD_STAGES].y
                                               : st_q[rva_pkg::CORD_STAGES].y;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule
`default_nettype wire

>>> rtl/rva_axis_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rva_axis_norm
// Pipelined axis normalization: block shift, isqrt, reciprocal, scale.
// ----------------------------------------------------------------------------
module rva_axis_norm (
  input  logic           clk_i,
  input  logic           en_i,
  input  rva_pkg::comp_t axis_i [3],
  output rva_pkg::unit_t unit_o [3]
);

  typedef logic [rva_pkg::CW-1:0] mag_t;

  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       neg;
  } mn_t;

  typedef struct packed {
    logic [61:0] v;
    logic [62:0] r;
  } sq_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] q;
    logic [30:0] len;
  } div_t;

  function automatic logic [4:0] lead_pos(input mag_t v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < rva_pkg::CW; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic sq_t sqrt_stage(input sq_t s, input int unsigned k);
    sq_t         o;
    logic [63:0] b;
    logic [63:0] t;
    int unsigned st;
    o = s;
    for (int j = 0; j < rva_pkg::SQ_PER; j++) begin
      st = k * rva_pkg::SQ_PER + j;
      if (st < rva_pkg::SQ_STEPS) begin
        b = 64'(1) << (62 - 2 * st);
        t = 64'(o.r) + b;
        if (64'(o.v) >= t) begin
          o.v = 62'(64'(o.v) - t);
          o.r = 63'((64'(o.r) >> 1) + b);
        end else begin
          o.r = o.r >> 1;
        end
      end
    end
    return o;
  endfunction

  // restoring divide of 2^60 + len/2 by len, low dividend bits = len/2
  function automatic div_t div_stage(input div_t s, input int unsigned k);
    div_t        o;
    logic [31:0] t;
    logic [31:0] nlow;
    int unsigned st;
    o    = s;
    nlow = 32'(s.len >> 1);
    for (int j = 0; j < rva_pkg::DIV_PER; j++) begin
      st = k * rva_pkg::DIV_PER + j;
      t  = {o.rem, nlow[5'(31 - st)]};
      if (t >= 32'(o.len)) begin
        o.rem = 31'(t - 32'(o.len));
        o.q   = {o.q[30:0], 1'b1};
      end else begin
        o.rem = t[30:0];
        o.q   = {o.q[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  mag_t           mag_d [3];
  mag_t           mx_d;
  mag_t           mag_q [3];
  logic [2:0]     neg_q;
  mag_t           mx_q;
  logic [4:0]     pos;
  mag_t           sh;
  mn_t            mn_d;
  mn_t            md_q [rva_pkg::MD_DEPTH];
  logic [59:0]    sqr_q [3];
  sq_t            sq_q [rva_pkg::SQ_STAGES+1];
  div_t           div_init;
  div_t           div_q [rva_pkg::DIV_STAGES];
  logic [61:0]    pr_q [3];
  logic [2:0]     pneg_q;
  logic [31:0]    qv [3];
  rva_pkg::unit_t unit_q [3];

  always_comb begin
    mx_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = axis_i[i][rva_pkg::CW-1] ? mag_t'(-axis_i[i]) : mag_t'(axis_i[i]);
      if (mag_d[i] > mx_d) mx_d = mag_d[i];
    end
  end

  // largest magnitude lands in [2^29, 2^30)
  always_comb begin
    pos = lead_pos(mx_q);
    sh  = '0;
    for (int i = 0; i < 3; i++) begin
      if (pos >= 5'd30) begin
        sh = mag_q[i] >> (pos - 5'd29);
      end else begin
        sh = mag_q[i] << (5'd29 - pos);
      end
      mn_d.m[i] = sh[29:0];
    end
    mn_d.neg = neg_q;
  end

  always_comb begin
    div_init.rem = 31'(1) << 28;
    div_init.q   = '0;
    div_init.len = sq_q[rva_pkg::SQ_STAGES].r[30:0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = 32'((pr_q[i] + (62'(1) << 29)) >> 30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= mag_d[i];
        neg_q[i] <= axis_i[i][rva_pkg::CW-1];
      end
      mx_q  <= mx_d;
      md_q[0] <= mn_d;
      for (int i = 1; i < rva_pkg::MD_DEPTH; i++) md_q[i] <= md_q[i-1];
      for (int i = 0; i < 3; i++) sqr_q[i] <= 60'(md_q[0].m[i]) * 60'(md_q[0].m[i]);
      sq_q[0].v <= 62'(sqr_q[0]) + 62'(sqr_q[1]) + 62'(sqr_q[2]);
      sq_q[0].r <= '0;
      for (int k = 0; k < rva_pkg::SQ_STAGES; k++) sq_q[k+1] <= sqrt_stage(sq_q[k], k);
      div_q[0] <= div_stage(div_init, 0);
      for (int k = 1; k < rva_pkg::DIV_STAGES; k++) div_q[k] <= div_stage(div_q[k-1], k);
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= 62'(md_q[rva_pkg::MD_DEPTH-1].m[i])
                   * 62'(div_q[rva_pkg::DIV_STAGES-1].q);
      end
      pneg_q <= md_q[rva_pkg::MD_DEPTH-1].neg;
      for (int i = 0; i < 3; i++) begin
        unit_q[i] <= pneg_q[i] ? -rva_pkg::unit_t'(qv[i]) : rva_pkg::unit_t'(qv[i]);
      end
    end
  end

  assign unit_o = unit_q;

endmodule
`default_nettype wire

>>> rtl/rotate_vector_about_axis_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_vector_about_axis_core
// Rodrigues rotation of a Q16.16 3-vector about an arbitrary axis.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat carries the
// vector, the Q4.28 angle and the axis (any length). Output channel
// (out_valid_o / out_ready_i / out_data_o): one beat per input beat, in order,
// with the rotated vector, axis_zero and saturated.
// Throughput: one beat per cycle while the output buffer has room.
// The depth is set by the axis path: 16 stages of integer square root
// and 16 stages of reciprocal division, two steps each; the 17-stage
// CORDIC runs alongside and is delayed to match.
// The pipeline moves as a whole; a two-beat output buffer follows it. While
// the buffer has room the pipeline advances, so a waiting result does not
// block input. When the receiver stalls and the buffer fills, in_ready_o
// drops and every stage holds its contents until space frees up.
// Reset clears the valid bits and the buffer count; nothing else needs it.
// A zero axis passes the vector through with axis_zero set.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rva_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rva_pkg::out_t out_data_o
);

  localparam int NL = rva_pkg::NORM_LAT;
  localparam int PL = rva_pkg::PIPE_LAT;
  localparam logic signed [40:0] RMax = 41'sd2147483647;
  localparam logic signed [40:0] RMin = -41'sd2147483648;

  // round at bit 30, arithmetic shift
  function automatic logic signed [71:0] rnd30(input logic signed [71:0] v);
    return (v + 72'sd536870912) >>> 30;
  endfunction

  // global stage enable and output buffer control
  logic       en;
  logic       in_fire;
  logic       push;
  logic       pop;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;

  // valid bits and side data, one entry per stage
  logic [PL-1:0]  vld_q;
  rva_pkg::comp_t a_q [PL][3];
  logic           zero_q [PL];

  rva_pkg::comp_t axis_in [3];
  rva_pkg::unit_t unit [3];
  rva_pkg::trig_t cos_w;
  rva_pkg::trig_t sin_w;
  rva_pkg::trig_t cd_q [rva_pkg::CS_DLY];
  rva_pkg::trig_t sd_q [rva_pkg::CS_DLY];

  // T1: dot and cross products
  logic signed [63:0] pd_q [3];
  logic signed [63:0] pc_q [3];
  logic signed [63:0] pm_q [3];
  rva_pkg::unit_t     n1_q [3];
  rva_pkg::trig_t     c1_q, s1_q;
  // T2: rounded a.n and n x a
  logic signed [33:0] d_q;
  logic signed [33:0] b2_q [3];
  rva_pkg::unit_t     n2_q [3];
  rva_pkg::trig_t     c2_q, s2_q;
  // T3: (a.n) n
  logic signed [67:0] pp_q [3];
  logic signed [33:0] b3_q [3];
  rva_pkg::trig_t     c3_q, s3_q;
  // T4: parallel and perpendicular parts
  logic signed [33:0] apar_d [3];
  logic signed [33:0] apar4_q [3];
  logic signed [34:0] perp_q [3];
  logic signed [33:0] b4_q [3];
  rva_pkg::trig_t     c4_q, s4_q;
  // T5: perp*cos and (n x a)*sin
  logic signed [69:0] m1_q [3];
  logic signed [69:0] m2_q [3];
  logic signed [33:0] apar5_q [3];
  // T6: unclamped result
  logic signed [40:0] r_q [3];

  rva_pkg::out_t      fin;
  rva_pkg::comp_t     rc [3];
  logic               sat;
  rva_pkg::out_t      head_q;
  rva_pkg::out_t      skid_q;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;
  assign in_fire    = in_valid_i & en;
  assign push       = en & vld_q[PL-1];
  assign pop        = out_valid_o & out_ready_i;

  assign axis_in[0] = in_data_i.axis_x;
  assign axis_in[1] = in_data_i.axis_y;
  assign axis_in[2] = in_data_i.axis_z;

  rva_axis_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .axis_i (axis_in),
    .unit_o (unit)
  );

  rva_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.angle),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PL-2:0], in_fire};
    end
  end

  // T4 parallel part, needed for perp in the same stage
  always_comb begin
    for (int i = 0; i < 3; i++) apar_d[i] = 34'(rnd30(72'(pp_q[i])));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0][0] <= in_data_i.vec_x;
      a_q[0][1] <= in_data_i.vec_y;
      a_q[0][2] <= in_data_i.vec_z;
      zero_q[0] <= (in_data_i.axis_x == '0) && (in_data_i.axis_y == '0)
                   && (in_data_i.axis_z == '0);
      for (int s = 1; s < PL; s++) begin
        a_q[s]    <= a_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
      cd_q[0] <= cos_w;
      sd_q[0] <= sin_w;
      for (int s = 1; s < rva_pkg::CS_DLY; s++) begin
        cd_q[s] <= cd_q[s-1];
        sd_q[s] <= sd_q[s-1];
      end

      // T1
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= 64'(a_q[NL-1][i]) * 64'(unit[i]);
        pc_q[i] <= 64'(unit[(i == 2) ? 0 : i + 1]) * 64'(a_q[NL-1][(i == 0) ? 2 : i - 1]);
        pm_q[i] <= 64'(unit[(i == 0) ? 2 : i - 1]) * 64'(a_q[NL-1][(i == 2) ? 0 : i + 1]);
        n1_q[i] <= unit[i];
      end
      c1_q <= cd_q[rva_pkg::CS_DLY-1];
      s1_q <= sd_q[rva_pkg::CS_DLY-1];

      // T2
      d_q <= 34'(rnd30(72'(pd_q[0]) + 72'(pd_q[1]) + 72'(pd_q[2])));
      for (int i = 0; i < 3; i++) begin
        b2_q[i] <= 34'(rnd30(72'(pc_q[i]) - 72'(pm_q[i])));
        n2_q[i] <= n1_q[i];
      end
      c2_q <= c1_q;
      s2_q <= s1_q;

      // T3
      for (int i = 0; i < 3; i++) begin
        pp_q[i] <= 68'(d_q) * 68'(n2_q[i]);
        b3_q[i] <= b2_q[i];
      end
      c3_q <= c2_q;
      s3_q <= s2_q;

      // T4
      for (int i = 0; i < 3; i++) begin
        apar4_q[i] <= apar_d[i];
        perp_q[i]  <= 35'(a_q[NL+2][i]) - 35'(apar_d[i]);
        b4_q[i]    <= b3_q[i];
      end
      c4_q <= c3_q;
      s4_q <= s3_q;

      // T5
      for (int i = 0; i < 3; i++) begin
        m1_q[i]    <= 70'(perp_q[i]) * 70'(c4_q);
        m2_q[i]    <= 70'(b4_q[i]) * 70'(s4_q);
        apar5_q[i] <= apar4_q[i];
      end

      // T6
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= 41'(rnd30(72'(m1_q[i]) + 72'(m2_q[i]))) + 41'(apar5_q[i]);
      end
    end
  end

  // clamp to the component range; a zero axis passes the vector through
  always_comb begin
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (r_q[i] > RMax) begin
        rc[i] = rva_pkg::comp_t'(RMax);
        sat   = 1'b1;
      end else if (r_q[i] < RMin) begin
        rc[i] = rva_pkg::comp_t'(RMin);
        sat   = 1'b1;
      end else begin
        rc[i] = rva_pkg::comp_t'(r_q[i]);
      end
    end
    if (zero_q[PL-1]) begin
      fin.rot_x     = a_q[PL-1][0];
      fin.rot_y     = a_q[PL-1][1];
      fin.rot_z     = a_q[PL-1][2];
      fin.axis_zero = 1'b1;
      fin.saturated = 1'b0;
    end else begin
      fin.rot_x     = rc[0];
      fin.rot_y     = rc[1];
      fin.rot_z     = rc[2];
      fin.axis_zero = 1'b0;
      fin.saturated = sat;
    end
  end

  // two-beat output buffer
  assign cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
      head_q <= fin;
    end else if (pop && (cnt_q == 2'd2)) begin
      head_q <= skid_q;
    end
    if (push && (cnt_q == 2'd1) && !pop) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = head_q;

`ifndef NO_ASSERTIONS
  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == 2'd1) && push && !pop) |=> !in_ready_o)
    else $error("buffer filled but input still ready");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted beat missing from first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.axis_zero && out_data_o.saturated))
    else $error("zero axis beat flagged saturated");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the axis-angle rotation core.
// ----------------------------------------------------------------------------
// A table of directed beats (zero axis, extremes, half-turn and wrap angles,
// saturating cases) is followed by random beats from a mix of generators.
// Beats with no typed-in result run through a local fixed-point model of
// the Rodrigues rotation; output beats are compared field by field, in order.
// Random idling on both sides, one drain pause, and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM   = 530;
  localparam int QUIET_FROM = 480;
  localparam int WDOG_LIMIT = 2000;
  localparam int MAX_SHOWN  = 10;

  localparam longint unsigned P62   = 64'h4000_0000_0000_0000;
  localparam longint          I64MX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint          I64MN = 64'sh8000_0000_0000_0000;
  localparam longint          ANG_PI_C   = 843314857;
  localparam longint          ANG_2PI_C  = 1686629713;
  localparam longint          ANG_HPI_C  = 421657428;
  localparam longint          GAIN_C     = 652032874;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  rva_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_ready;
  rva_pkg::out_t  out_data;

  rva_pkg::out_t  rot_expect_q[$];
  rva_pkg::in_t   stim_q[$];
  logic           stim_known_q[$];
  rva_pkg::out_t  stim_known_val_q[$];
  int    mismatches;
  int    out_count;
  int    in_count;
  int    sat_seen;
  int    zero_seen;
  int    idle_cnt;
  bit    timed_out;
  bit    quiet;

  longint atan_lut [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1};

  rotate_vector_about_axis_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Saturating 64-bit arithmetic; ovf collects every clip
  // ---------------------------------------------------------------------------
  function automatic longint sat_add(longint a, longint b, inout bit ovf);
    if (b > 0 && a > I64MX - b) begin
      ovf = 1'b1;
      return I64MX;
    end
    if (b < 0 && a < I64MN - b) begin
      ovf = 1'b1;
      return I64MN;
    end
    return a + b;
  endfunction

  function automatic longint sat_neg(longint a, inout bit ovf);
    if (a == I64MN) begin
      ovf = 1'b1;
      return I64MX;
    end
    return -a;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  // exact product in 128 bits, then clipped to the signed 64-bit range
  function automatic longint sat_mul(longint a, longint b, inout bit ovf);
    logic signed [127:0] p;
    p = 128'(signed'(a)) * 128'(signed'(b));
    if (p > 128'(I64MX)) begin
      ovf = 1'b1;
      return I64MX;
    end
    if (p < 128'(I64MN)) begin
      ovf = 1'b1;
      return I64MN;
    end
    return p[63:0];
  endfunction

  function automatic longint round_q30(longint v, inout bit ovf);
    return sat_add(v, 64'sd1 << 29, ovf) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = P62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected output beat for one input beat
  // ---------------------------------------------------------------------------
  function automatic rva_pkg::out_t rotation_of(rva_pkg::in_t b);
    longint          v[3], ax[3], n[3], bx[3], par[3];
    longint unsigned m[3], mx, sq, len, inv;
    longint          th, x, y, z, dx, dy, c, s, d, perp, r, q;
    bit              ovf, flip;
    int              j, k;
    rva_pkg::out_t   o;
    v  = '{longint'(b.vec_x), longint'(b.vec_y), longint'(b.vec_z)};
    ax = '{longint'(b.axis_x), longint'(b.axis_y), longint'(b.axis_z)};
    o  = '0;
    if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) begin
      o.rot_x = b.vec_x;
      o.rot_y = b.vec_y;
      o.rot_z = b.vec_z;
      o.axis_zero = 1'b1;
      return o;
    end
    // block-normalize, then scale by the reciprocal length
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(ax[i]);
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq += m[i] * m[i];
    len = int_sqrt(sq);
    inv = ((64'd1 << 60) + len / 2) / len;
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * inv + (64'd1 << 29)) >> 30;
      n[i] = ax[i] < 0 ? -q : q;
    end
    // angle reduction and CORDIC
    th = longint'(b.angle);
    flip = 1'b0;
    if (th > ANG_PI_C) th -= ANG_2PI_C;
    else if (th < -ANG_PI_C) th += ANG_2PI_C;
    if (th > ANG_HPI_C) begin
      th -= ANG_PI_C;
      flip = 1'b1;
    end else if (th < -ANG_HPI_C) begin
      th += ANG_PI_C;
      flip = 1'b1;
    end
    x = GAIN_C;
    y = 0;
    z = th * 4;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_lut[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_lut[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    // Rodrigues combination
    ovf = 1'b0;
    d = sat_add(sat_add(sat_mul(v[0], n[0], ovf), sat_mul(v[1], n[1], ovf), ovf),
                sat_mul(v[2], n[2], ovf), ovf);
    d = round_q30(d, ovf);
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      par[i] = round_q30(sat_mul(d, n[i], ovf), ovf);
      bx[i] = round_q30(sat_add(sat_mul(n[j], v[k], ovf),
                                sat_neg(sat_mul(n[k], v[j], ovf), ovf), ovf), ovf);
    end
    for (int i = 0; i < 3; i++) begin
      perp = sat_add(v[i], sat_neg(par[i], ovf), ovf);
      r = sat_add(sat_mul(perp, c, ovf), sat_mul(bx[i], s, ovf), ovf);
      r = sat_add(round_q30(r, ovf), par[i], ovf);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        ovf = 1'b1;
      end
      if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        ovf = 1'b1;
      end
      case (i)
        0: o.rot_x = r[31:0];
        1: o.rot_y = r[31:0];
        default: o.rot_z = r[31:0];
      endcase
    end
    o.saturated = ovf;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic rva_pkg::comp_t rand_comp(int mode);
    case (mode)
      0: return rva_pkg::comp_t'($urandom);
      1: return rva_pkg::comp_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return rva_pkg::comp_t'($urandom_range(0, 64)) - 32;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0001;
          default: return 32'shffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic rva_pkg::in_t rand_beat();
    rva_pkg::in_t b;
    int           vm, am;
    vm = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
    am = $urandom_range(0, 3);
    b.vec_x  = rand_comp(vm);
    b.vec_y  = rand_comp(vm);
    b.vec_z  = rand_comp(vm);
    b.angle  = rva_pkg::angle_t'($urandom);
    b.axis_x = rand_comp(am);
    b.axis_y = rand_comp(am);
    b.axis_z = rand_comp(am);
    // a few zero axes and a few single-component axes
    case ($urandom_range(0, 19))
      0: {b.axis_x, b.axis_y, b.axis_z} = '0;
      1: {b.axis_y, b.axis_z} = '0;
      default: ;
    endcase
    return b;
  endfunction

  localparam rva_pkg::comp_t  ONE   = 32'sh0001_0000;
  localparam rva_pkg::comp_t  MAXC  = 32'sh7fff_ffff;
  localparam rva_pkg::comp_t  MINC  = 32'sh8000_0000;
  localparam rva_pkg::angle_t A_HPI = 32'sd421657428;
  localparam rva_pkg::angle_t A_PI  = 32'sd843314857;

  // vec x/y/z, angle, axis x/y/z; known = expected result typed in
  typedef struct {
    rva_pkg::in_t  beat;
    bit            known;
    rva_pkg::out_t res;
  } row_t;

  row_t directed_tbl [N_DIRECTED];

  task automatic build_table();
    directed_tbl[0]  = '{'{ONE, 2*ONE, -3*ONE, A_HPI, 0, 0, 0}, 1,
                         '{ONE, 2*ONE, -3*ONE, 1'b1, 1'b0}};
    directed_tbl[1]  = '{'{MAXC, MINC, MAXC, 32'sh7fff_ffff, 0, 0, 0}, 1,
                         '{MAXC, MINC, MAXC, 1'b1, 1'b0}};
    directed_tbl[2]  = '{'{MINC, MINC, MINC, MINC, 0, 0, 0}, 1,
                         '{MINC, MINC, MINC, 1'b1, 1'b0}};
    directed_tbl[3]  = '{'{ONE, 0, 0, A_HPI, 0, 0, ONE}, 0, '0};
    directed_tbl[4]  = '{'{ONE, ONE, ONE, A_PI, ONE, ONE, ONE}, 0, '0};
    directed_tbl[5]  = '{'{ONE, 0, 0, -A_PI, 0, ONE, 0}, 0, '0};
    directed_tbl[6]  = '{'{ONE, 2*ONE, 3*ONE, 0, 0, 0, -ONE}, 0, '0};
    directed_tbl[7]  = '{'{ONE, 0, ONE, 32'sh7fff_ffff, ONE, 0, 0}, 0, '0};
    directed_tbl[8]  = '{'{ONE, 0, ONE, MINC, ONE, 0, 0}, 0, '0};
    directed_tbl[9]  = '{'{ONE, 0, 0, A_PI + 1, 0, 0, ONE}, 0, '0};
    directed_tbl[10] = '{'{ONE, 0, 0, -A_PI - 1, 0, 0, ONE}, 0, '0};
    directed_tbl[11] = '{'{MAXC, MAXC, MAXC, A_HPI, ONE, -ONE, 0}, 0, '0};
    directed_tbl[12] = '{'{MINC, MINC, MINC, -A_HPI, MINC, MINC, MINC}, 0, '0};
    directed_tbl[13] = '{'{MAXC, MINC, MAXC, A_HPI / 2, MAXC, MAXC, MAXC}, 0, '0};
    directed_tbl[14] = '{'{ONE, ONE, 0, A_HPI, 1, 0, 0}, 0, '0};
    directed_tbl[15] = '{'{ONE, ONE, 0, A_HPI, -1, 1, 0}, 0, '0};
    directed_tbl[16] = '{'{ONE, ONE, ONE, A_HPI, 32'sh4000_0000, 1, 0}, 0, '0};
    directed_tbl[17] = '{'{-ONE, 5, 7, A_HPI + 1, 0, MINC, 0}, 0, '0};
    directed_tbl[18] = '{'{ONE, -ONE, ONE, -A_HPI - 1, 3, 4, 12}, 0, '0};
    directed_tbl[19] = '{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f,
                           32'sh5555_5555, 32'sh2aaa_aaaa, 32'shd555_5555,
                           32'shf0f0_f0f0}, 0, '0};
    directed_tbl[20] = '{'{32'shaaaa_aaaa, 32'sh5555_5555, 32'shf0f0_f0f0,
                           32'shaaaa_aaaa, 32'shd555_5555, 32'sh2aaa_aaaa,
                           32'sh0f0f_0f0f}, 0, '0};
    directed_tbl[21] = '{'{0, 0, 0, 1, ONE, 2*ONE, 3*ONE}, 0, '0};
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one beat per call, random idle bursts before it
  // ---------------------------------------------------------------------------
  task automatic send_beat(rva_pkg::in_t b, bit known, rva_pkg::out_t res);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    stim_q.push_back(b);
    stim_known_q.push_back(known);
    stim_known_val_q.push_back(res);
    do @(posedge clk); while (!in_ready);
  endtask

  // Expectations are pushed at the accepting edge, in acceptance order
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (stim_known_q[0]) rot_expect_q.push_back(stim_known_val_q[0]);
      else rot_expect_q.push_back(rotation_of(stim_q[0]));
      void'(stim_q.pop_front());
      void'(stim_known_q.pop_front());
      void'(stim_known_val_q.pop_front());
      in_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, compare on each accepted output beat
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready <= 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        out_count++;
        if (rot_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected output beat %h", out_data);
        end else begin
          rva_pkg::out_t e;
          e = rot_expect_q.pop_front();
          if (out_data.axis_zero) zero_seen++;
          if (out_data.saturated) sat_seen++;
          if (out_data.rot_x !== e.rot_x || out_data.rot_y !== e.rot_y ||
              out_data.rot_z !== e.rot_z || out_data.axis_zero !== e.axis_zero ||
              out_data.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("beat %0d: exp x=%h y=%h z=%h zero=%b sat=%b, got x=%h y=%h z=%h zero=%b sat=%b",
                       out_count, e.rot_x, e.rot_y, e.rot_z, e.axis_zero, e.saturated,
                       out_data.rot_x, out_data.rot_y, out_data.rot_z,
                       out_data.axis_zero, out_data.saturated);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches = 0;
    out_count  = 0;
    in_count   = 0;
    sat_seen   = 0;
    zero_seen  = 0;
    idle_cnt   = 0;
    quiet      = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    build_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[i])
      send_beat(directed_tbl[i].beat, directed_tbl[i].known, directed_tbl[i].res);
    in_valid <= 1'b0;

    // hold off until the pipe drains once
    wait (rot_expect_q.size() == 0);
    @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      send_beat(rand_beat(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    wait (rot_expect_q.size() == 0);
    repeat (rva_pkg::PIPE_LAT + 10) @(posedge clk);

    $display("Covered %0d input beats, %0d output beats (%0d zero-axis, %0d saturated).",
             in_count, out_count, zero_seen, sat_seen);
    if (mismatches == 0 && rot_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rva_pkg.sv
rtl/rva_cordic.sv
rtl/rva_axis_norm.sv
rtl/rotate_vector_about_axis_core.sv
tb/sv/tb_top.sv
